### sv/ambd_pkg.sv
// ----------------------------------------------------------------------------
// Main bus decoder package
// Shared widths, access kinds, target codes, address map constants and the
// status sequence table of the main CPU bus decoder.
// ----------------------------------------------------------------------------
package ambd_pkg;

    localparam int ADDR_W = 16;
    localparam int BYTE_W = 8;
    localparam int OP_W   = 3;
    localparam int TGT_W  = 3;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 56;

    typedef enum logic [OP_W-1:0] {
        OP_MEM_READ  = 3'd0,
        OP_MEM_WRITE = 3'd1,
        OP_PORT_IN   = 3'd2,
        OP_PORT_OUT  = 3'd3,
        OP_MCU_SCROLL = 3'd4
    } op_t;

    typedef enum logic [TGT_W-1:0] {
        TGT_NONE     = 3'd0,
        TGT_MAIN_MEM = 3'd1,
        TGT_BANK_ROM = 3'd2,
        TGT_MCU      = 3'd3,
        TGT_INTERNAL = 3'd4
    } target_t;

    // Port numbers decoded on port out and port in (low address byte).
    localparam logic [BYTE_W-1:0] PORT_SOUND_HOLD    = 8'h00;
    localparam logic [BYTE_W-1:0] PORT_SOUND_RELEASE = 8'h01;
    localparam logic [BYTE_W-1:0] PORT_IRQ_CLEAR     = 8'h06;
    localparam logic [BYTE_W-1:0] PORT_IRQ_ENABLE    = 8'h07;
    localparam logic [BYTE_W-1:0] PORT_BANK0         = 8'h08;
    localparam logic [BYTE_W-1:0] PORT_BANK1         = 8'h09;
    localparam logic [BYTE_W-1:0] PORT_STATUS        = 8'h00;

    // Address map.
    localparam logic [ADDR_W-1:0] ADDR_LOW_END    = 16'h7fff;
    localparam logic [ADDR_W-1:0] ADDR_ROM_START  = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_ROM_END    = 16'hbfff;
    localparam logic [ADDR_W-1:0] ADDR_RAM_START  = 16'hc000;
    localparam logic [ADDR_W-1:0] ADDR_RAM_END    = 16'he7ff;
    localparam logic [ADDR_W-1:0] ADDR_VSCROLL_LO = 16'he800;
    localparam logic [ADDR_W-1:0] ADDR_VSCROLL_HI = 16'he801;
    localparam logic [ADDR_W-1:0] ADDR_HSCROLL    = 16'he802;
    localparam logic [ADDR_W-1:0] ADDR_MCU        = 16'he803;
    localparam logic [ADDR_W-1:0] ADDR_HIGH_START = 16'hf000;

    localparam int ROM_OFS_W = 14;

    localparam logic [BYTE_W-1:0] OPEN_BUS    = 8'hff;
    localparam logic [BYTE_W-1:0] STATUS_MASK = 8'hf9;

    // Status sequence base byte; phase 3 repeats the first entry.
    function automatic logic [BYTE_W-1:0] status_base(input logic [1:0] phase);
        logic [BYTE_W-1:0] base;
        begin
            case (phase)
                2'd1:    base = 8'h55;
                2'd2:    base = 8'h00;
                default: base = 8'hc7;
            endcase
            return base;
        end
    endfunction

endpackage

### sv/arcade_main_bus_decoder.sv
// ----------------------------------------------------------------------------
// Arcade main bus decoder
// Address decoder and control latches for the main CPU bus of an arcade board.
// ----------------------------------------------------------------------------
// Each slave transaction carries one bus access: the kind of access on
// s_axis_tuser and the address, write byte and MCU latch signals on
// s_axis_tdata. Each access gives exactly one master transaction that names
// the target (m_axis_tuser) and carries the memory address, strobes, read
// byte and the current values of the control latches (m_axis_tdata).
//
// The access is captured in an input register, decoded by one level of
// compare and select logic, and the result is held in an output register.
// One access is taken every cycle while the receiver keeps up; the control
// latches are updated in the same cycle that a result is written, so
// back-to-back accesses see each other's effects in order.
//
// After reset both registers are empty, the scroll registers, bank bit and
// IRQ enable are zero, the status sequence starts at its first byte and the
// sound CPU is held in reset. When the receiver stalls, the result waits in
// the output register and one more access waits in the input register; then
// s_axis_tready drops until the receiver takes the result.
// ----------------------------------------------------------------------------
module arcade_main_bus_decoder (
    input  logic                               clk,
    input  logic                               rst_n,
    // Slave side.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [15:0] address, [23:16] write_data, [31:24] mcu_read_data,
    // [32] mcu_host_pending, [33] mcu_reply_pending, [39:34] zero
    input  logic [ambd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // [2:0] operation
    input  logic [ambd_pkg::OP_W-1:0]          s_axis_tuser,
    // Master side.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [15:0] mem_address, [16] mem_write, [24:17] read_data, [25] mcu_write,
    // [41:26] vertical scroll, [49:42] horizontal scroll, [50] bank_out,
    // [51] irq_enable_out, [52] irq_clear, [53] sound_hold_out, [55:54] zero
    output logic [ambd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [2:0] target
    output logic [ambd_pkg::TGT_W-1:0]         m_axis_tuser
);

    localparam int AW = ambd_pkg::ADDR_W;
    localparam int BW = ambd_pkg::BYTE_W;

    // Input register.
    logic                                in_valid_reg;
    logic [ambd_pkg::IN_DATA_W-1:0]      in_data_reg;
    logic [ambd_pkg::OP_W-1:0]           in_op_reg;

    // Output register.
    logic                                out_valid_reg;
    logic [ambd_pkg::OUT_DATA_W-1:0]     out_data_reg;
    logic [ambd_pkg::TGT_W-1:0]          out_tgt_reg;

    // Control latches.
    logic [1:0]    status_phase_reg, status_phase_next;
    logic [AW-1:0] vscroll_reg, vscroll_next;
    logic [BW-1:0] hscroll_reg, hscroll_next;
    logic          bank_reg, bank_next;
    logic          irq_enable_reg, irq_enable_next;
    logic          sound_hold_reg, sound_hold_next;

    // Decoded access fields.
    logic [AW-1:0] addr;
    logic [BW-1:0] wr_byte;
    logic [BW-1:0] mcu_byte;
    logic          host_pending;
    logic          reply_pending;
    logic [BW-1:0] port;

    // Decode results.
    ambd_pkg::target_t tgt;
    logic [AW-1:0] mem_addr;
    logic          mem_wr;
    logic [BW-1:0] rd_byte;
    logic          mcu_wr;
    logic          irq_clr;

    logic          in_ram_range;
    logic          advance;

    // The input register moves into the output register whenever the output
    // register is empty or being drained this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign addr          = in_data_reg[15:0];
    assign wr_byte       = in_data_reg[23:16];
    assign mcu_byte      = in_data_reg[31:24];
    assign host_pending  = in_data_reg[32];
    assign reply_pending = in_data_reg[33];
    assign port          = addr[BW-1:0];

    // Main memory covers the low 32K, C000-E7FF and F000-FFFF.
    assign in_ram_range = (addr <= ambd_pkg::ADDR_LOW_END)
                       || ((addr >= ambd_pkg::ADDR_RAM_START)
                           && (addr <= ambd_pkg::ADDR_RAM_END))
                       || (addr >= ambd_pkg::ADDR_HIGH_START);

    always_comb
    begin
        tgt               = ambd_pkg::TGT_NONE;
        mem_addr          = '0;
        mem_wr            = 1'b0;
        rd_byte           = '0;
        mcu_wr            = 1'b0;
        irq_clr           = 1'b0;
        status_phase_next = status_phase_reg;
        vscroll_next      = vscroll_reg;
        hscroll_next      = hscroll_reg;
        bank_next         = bank_reg;
        irq_enable_next   = irq_enable_reg;
        sound_hold_next   = sound_hold_reg;

        unique case (ambd_pkg::op_t'(in_op_reg))
            ambd_pkg::OP_MEM_READ:
            begin
                if (addr == ambd_pkg::ADDR_MCU)
                begin
                    tgt     = ambd_pkg::TGT_MCU;
                    rd_byte = mcu_byte;
                end
                else if (in_ram_range)
                begin
                    tgt      = ambd_pkg::TGT_MAIN_MEM;
                    mem_addr = addr;
                end
                else if ((addr >= ambd_pkg::ADDR_ROM_START)
                         && (addr <= ambd_pkg::ADDR_ROM_END))
                begin
                    // Bank bit becomes address bit 14 of the ROM window.
                    tgt      = ambd_pkg::TGT_BANK_ROM;
                    mem_addr = {1'b0, bank_reg, addr[ambd_pkg::ROM_OFS_W-1:0]};
                end
                else
                begin
                    tgt     = ambd_pkg::TGT_INTERNAL;
                    rd_byte = ambd_pkg::OPEN_BUS;
                end
            end
            ambd_pkg::OP_MEM_WRITE:
            begin
                if (addr <= ambd_pkg::ADDR_ROM_END)
                begin
                    tgt = ambd_pkg::TGT_NONE;
                end
                else if (addr == ambd_pkg::ADDR_VSCROLL_LO)
                begin
                    vscroll_next = {vscroll_reg[AW-1:BW], wr_byte};
                end
                else if (addr == ambd_pkg::ADDR_VSCROLL_HI)
                begin
                    vscroll_next = {wr_byte, vscroll_reg[BW-1:0]};
                end
                else if (addr == ambd_pkg::ADDR_HSCROLL)
                begin
                    hscroll_next = wr_byte;
                end
                else if (addr == ambd_pkg::ADDR_MCU)
                begin
                    tgt    = ambd_pkg::TGT_MCU;
                    mcu_wr = 1'b1;
                end
                else if (in_ram_range)
                begin
                    tgt      = ambd_pkg::TGT_MAIN_MEM;
                    mem_addr = addr;
                    mem_wr   = 1'b1;
                end
            end
            ambd_pkg::OP_PORT_IN:
            begin
                tgt = ambd_pkg::TGT_INTERNAL;
                if (port == ambd_pkg::PORT_STATUS)
                begin
                    // Handshake flags read back inverted in bits 1 and 2.
                    rd_byte = (ambd_pkg::status_base(status_phase_reg)
                               & ambd_pkg::STATUS_MASK)
                            | {5'b0, ~reply_pending, ~host_pending, 1'b0};
                    status_phase_next = status_phase_reg + 2'd1;
                end
                else
                begin
                    rd_byte = ambd_pkg::OPEN_BUS;
                end
            end
            ambd_pkg::OP_PORT_OUT:
            begin
                case (port)
                    ambd_pkg::PORT_SOUND_HOLD:    sound_hold_next = 1'b1;
                    ambd_pkg::PORT_SOUND_RELEASE: sound_hold_next = 1'b0;
                    ambd_pkg::PORT_IRQ_CLEAR:
                    begin
                        irq_enable_next = 1'b0;
                        irq_clr         = 1'b1;
                    end
                    ambd_pkg::PORT_IRQ_ENABLE:    irq_enable_next = 1'b1;
                    ambd_pkg::PORT_BANK0:         bank_next       = 1'b0;
                    ambd_pkg::PORT_BANK1:         bank_next       = 1'b1;
                    default:                      ;
                endcase
            end
            ambd_pkg::OP_MCU_SCROLL:
            begin
                if (addr[0])
                    vscroll_next = {wr_byte, vscroll_reg[BW-1:0]};
                else
                    vscroll_next = {vscroll_reg[AW-1:BW], wr_byte};
            end
            default:
            begin
                tgt = ambd_pkg::TGT_NONE;
            end
        endcase
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata;
            in_op_reg   <= s_axis_tuser;
        end
    end

    // Control latches change only when an access is committed to the output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_phase_reg <= '0;
            vscroll_reg      <= '0;
            hscroll_reg      <= '0;
            bank_reg         <= 1'b0;
            irq_enable_reg   <= 1'b0;
            sound_hold_reg   <= 1'b1;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                status_phase_reg <= status_phase_next;
                vscroll_reg      <= vscroll_next;
                hscroll_reg      <= hscroll_next;
                bank_reg         <= bank_next;
                irq_enable_reg   <= irq_enable_next;
                sound_hold_reg   <= sound_hold_next;
                out_valid_reg    <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_tgt_reg  <= tgt;
            out_data_reg <= {2'b0, sound_hold_next, irq_clr, irq_enable_next, bank_next,
                             hscroll_next, vscroll_next, mcu_wr, rd_byte, mem_wr,
                             mem_addr};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_tgt_reg;

endmodule

### tb/sv/arcade_main_bus_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Main bus decoder testbench
// Sends bus accesses into the decoder, predicts each decoded result with an
// independent model of the address map and control latches, and checks every
// result transaction field by field, under random stalls on both sides.
// ----------------------------------------------------------------------------
module arcade_main_bus_decoder_tb;

    // One bus access as it travels on the slave side.
    typedef struct {
        logic [ambd_pkg::OP_W-1:0]   op;
        logic [ambd_pkg::ADDR_W-1:0] addr;
        logic [ambd_pkg::BYTE_W-1:0] wdata;
        logic [ambd_pkg::BYTE_W-1:0] mcu_byte;
        logic                        host_pending;
        logic                        reply_pending;
    } bus_access_t;

    // One decoded access as it travels on the master side.
    typedef struct {
        logic [ambd_pkg::TGT_W-1:0]  target;
        logic [ambd_pkg::ADDR_W-1:0] mem_addr;
        logic                        mem_wr;
        logic [ambd_pkg::BYTE_W-1:0] rdata;
        logic                        mcu_wr;
        logic [15:0]                 vscroll;
        logic [ambd_pkg::BYTE_W-1:0] hscroll;
        logic                        bank;
        logic                        irq_en;
        logic                        irq_clr;
        logic                        sound_hold;
    } bus_decode_t;

    // ------------------------------------------------------------------------
    // Decode scoreboard: keeps its own copy of the latches, works out the
    // decode of every accepted access and compares it with what comes out.
    // ------------------------------------------------------------------------
    class decode_scoreboard_t;
        bus_decode_t                 expected_decodes[$];
        logic [1:0]                  status_step;
        logic [15:0]                 vscroll;
        logic [ambd_pkg::BYTE_W-1:0] hscroll;
        logic                        bank;
        logic                        irq_en;
        logic                        sound_hold;
        int                          mismatches;
        int                          decodes_checked;
        int                          op_seen[8];

        function new();
            status_step = 2'd0;
            vscroll     = '0;
            hscroll     = '0;
            bank        = 1'b0;
            irq_en      = 1'b0;
            sound_hold  = 1'b1;
            mismatches  = 0;
            decodes_checked = 0;
            foreach (op_seen[i]) op_seen[i] = 0;
        endfunction

        function bus_decode_t decode_access(bus_access_t a);
            bus_decode_t                 d;
            logic [ambd_pkg::BYTE_W-1:0] port;
            logic [ambd_pkg::BYTE_W-1:0] base;
            port       = a.addr[7:0];
            d.target   = ambd_pkg::TGT_NONE;
            d.mem_addr = '0;
            d.mem_wr   = 1'b0;
            d.rdata    = '0;
            d.mcu_wr   = 1'b0;
            d.irq_clr  = 1'b0;
            case (a.op)
                ambd_pkg::OP_MEM_READ:
                begin
                    if (a.addr == ambd_pkg::ADDR_MCU)
                    begin
                        d.target = ambd_pkg::TGT_MCU;
                        d.rdata  = a.mcu_byte;
                    end
                    else if (a.addr <= 16'h7fff || a.addr >= 16'hf000 ||
                             (a.addr >= 16'hc000 && a.addr <= 16'he7ff))
                    begin
                        d.target   = ambd_pkg::TGT_MAIN_MEM;
                        d.mem_addr = a.addr;
                    end
                    else if (a.addr >= 16'h8000 && a.addr <= 16'hbfff)
                    begin
                        d.target   = ambd_pkg::TGT_BANK_ROM;
                        d.mem_addr = {1'b0, bank, a.addr[13:0]};
                    end
                    else
                    begin
                        d.target = ambd_pkg::TGT_INTERNAL;
                        d.rdata  = 8'hff;
                    end
                end
                ambd_pkg::OP_MEM_WRITE:
                begin
                    if (a.addr <= 16'hbfff)
                    begin
                        // Writes into the low map and the ROM window go nowhere.
                    end
                    else if (a.addr == ambd_pkg::ADDR_VSCROLL_LO)
                        vscroll[7:0] = a.wdata;
                    else if (a.addr == ambd_pkg::ADDR_VSCROLL_HI)
                        vscroll[15:8] = a.wdata;
                    else if (a.addr == ambd_pkg::ADDR_HSCROLL)
                        hscroll = a.wdata;
                    else if (a.addr == ambd_pkg::ADDR_MCU)
                    begin
                        d.target = ambd_pkg::TGT_MCU;
                        d.mcu_wr = 1'b1;
                    end
                    else if (a.addr <= 16'he7ff || a.addr >= 16'hf000)
                    begin
                        d.target   = ambd_pkg::TGT_MAIN_MEM;
                        d.mem_addr = a.addr;
                        d.mem_wr   = 1'b1;
                    end
                end
                ambd_pkg::OP_PORT_IN:
                begin
                    d.target = ambd_pkg::TGT_INTERNAL;
                    if (port == ambd_pkg::PORT_STATUS)
                    begin
                        // The fourth step of the sequence repeats the first byte.
                        case (status_step)
                            2'd1:    base = 8'h55;
                            2'd2:    base = 8'h00;
                            default: base = 8'hc7;
                        endcase
                        d.rdata = (base & 8'hf9) | {5'b0, ~a.reply_pending,
                                                    ~a.host_pending, 1'b0};
                        status_step = status_step + 2'd1;
                    end
                    else
                        d.rdata = 8'hff;
                end
                ambd_pkg::OP_PORT_OUT:
                begin
                    case (port)
                        ambd_pkg::PORT_SOUND_HOLD:    sound_hold = 1'b1;
                        ambd_pkg::PORT_SOUND_RELEASE: sound_hold = 1'b0;
                        ambd_pkg::PORT_IRQ_CLEAR:
                        begin
                            irq_en    = 1'b0;
                            d.irq_clr = 1'b1;
                        end
                        ambd_pkg::PORT_IRQ_ENABLE:    irq_en = 1'b1;
                        ambd_pkg::PORT_BANK0:         bank = 1'b0;
                        ambd_pkg::PORT_BANK1:         bank = 1'b1;
                        default:                      ;
                    endcase
                end
                ambd_pkg::OP_MCU_SCROLL:
                begin
                    if (a.addr[0])
                        vscroll[15:8] = a.wdata;
                    else
                        vscroll[7:0] = a.wdata;
                end
                default:
                    ;
            endcase
            d.vscroll    = vscroll;
            d.hscroll    = hscroll;
            d.bank       = bank;
            d.irq_en     = irq_en;
            d.sound_hold = sound_hold;
            return d;
        endfunction

        function void note_access(bus_access_t a);
            op_seen[a.op]++;
            expected_decodes.insert(expected_decodes.size(), decode_access(a));
        endfunction

        function int outstanding();
            return expected_decodes.size();
        endfunction

        task report_mismatch(string what, longint got, longint want);
            mismatches++;
            if (mismatches <= 40)
                $display("%0t ns: decode %0d, %s is %0h, expected %0h",
                         $time, decodes_checked, what, got, want);
        endtask

        task compare_field(string what, longint got, longint want);
            if (got != want)
                report_mismatch(what, got, want);
        endtask

        task check_decode(logic [ambd_pkg::TGT_W-1:0] tuser,
                          logic [ambd_pkg::OUT_DATA_W-1:0] tdata);
            bus_decode_t want;
            if (expected_decodes.size() == 0)
            begin
                report_mismatch("unexpected result transaction", tdata, 0);
                return;
            end
            want = expected_decodes.pop_front();
            compare_field("target",         tuser,          want.target);
            compare_field("mem_address",    tdata[15:0],    want.mem_addr);
            compare_field("mem_write",      tdata[16],      want.mem_wr);
            compare_field("read_data",      tdata[24:17],   want.rdata);
            compare_field("mcu_write",      tdata[25],      want.mcu_wr);
            compare_field("vertical scroll",   tdata[41:26], want.vscroll);
            compare_field("horizontal scroll", tdata[49:42], want.hscroll);
            compare_field("bank_out",       tdata[50],      want.bank);
            compare_field("irq_enable_out", tdata[51],      want.irq_en);
            compare_field("irq_clear",      tdata[52],      want.irq_clr);
            compare_field("sound_hold_out", tdata[53],      want.sound_hold);
            decodes_checked++;
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the ports of the block. Every input has a known value
    // from time zero.
    // ------------------------------------------------------------------------
    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [ambd_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic [ambd_pkg::OP_W-1:0]       s_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_tready = 1'b0;
    logic [ambd_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [ambd_pkg::TGT_W-1:0]      m_axis_tuser;

    // Idle chances in percent per cycle, and a long receiver hold-off that the
    // stimulus can request; the receiver counts it down itself.
    int tx_idle_pct = 6;
    int rx_idle_pct = 61;
    int rx_hold_cycles = 0;

    decode_scoreboard_t sb;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    arcade_main_bus_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic bus_access_t make_access(logic [ambd_pkg::OP_W-1:0] op,
                                                logic [15:0] addr,
                                                logic [7:0] wdata, logic [7:0] mcu_byte,
                                                logic host_pending, logic reply_pending);
        bus_access_t a;
        a.op            = op;
        a.addr          = addr;
        a.wdata         = wdata;
        a.mcu_byte      = mcu_byte;
        a.host_pending  = host_pending;
        a.reply_pending = reply_pending;
        return a;
    endfunction

    // Offers one access on the slave side, after any random idle cycles, and
    // returns once the transaction has been taken. The valid is only lowered
    // while idling, so back-to-back accesses keep it high.
    task automatic issue_access(bus_access_t a);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= a.op;
        s_tdata  <= {6'b0, a.reply_pending, a.host_pending, a.mcu_byte, a.wdata, a.addr};
        // Inputs and tready are read just after the edge, so they still hold
        // the values that decided the transaction at that edge.
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_access(a);
    endtask

    // Random access. Addresses lean toward the borders of the map and the
    // register addresses; port numbers lean toward the decoded ones.
    function automatic bus_access_t random_access();
        bus_access_t a;
        int          pick;
        logic [15:0] edges[14];
        edges = '{16'h0000, 16'h7fff, 16'h8000, 16'hbfff, 16'hc000, 16'he7ff,
                  16'he800, 16'he801, 16'he802, 16'he803, 16'he804, 16'hefff,
                  16'hf000, 16'hffff};
        pick = $urandom_range(99);
        if (pick < 28)      a.op = ambd_pkg::OP_MEM_READ;
        else if (pick < 52) a.op = ambd_pkg::OP_MEM_WRITE;
        else if (pick < 67) a.op = ambd_pkg::OP_PORT_IN;
        else if (pick < 82) a.op = ambd_pkg::OP_PORT_OUT;
        else if (pick < 94) a.op = ambd_pkg::OP_MCU_SCROLL;
        else                a.op = 3'($urandom_range(5, 7));
        a.addr = 16'($urandom);
        if (a.op == ambd_pkg::OP_PORT_IN || a.op == ambd_pkg::OP_PORT_OUT)
        begin
            if ($urandom_range(99) < 65)
                a.addr[7:0] = 8'($urandom_range(0, 9));
        end
        else if ($urandom_range(99) < 55)
        begin
            a.addr = edges[$urandom_range(13)];
            // Step just inside or outside a border now and then.
            if ($urandom_range(3) == 0)
                a.addr = a.addr + 16'($urandom_range(0, 2)) - 16'd1;
        end
        a.wdata         = 8'($urandom);
        a.mcu_byte      = 8'($urandom);
        a.host_pending  = 1'($urandom);
        a.reply_pending = 1'($urandom);
        return a;
    endfunction

    // Receiver: takes result transactions with random stalls, or holds off
    // for a requested stretch so that the block fills up.
    initial
    begin : result_sink
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_tready)
                sb.check_decode(m_axis_tuser, m_axis_tdata);
            if (rx_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                rx_hold_cycles--;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Hard limit on the run, far above the slowest correct run.
    initial
    begin : watchdog
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin : stimulus
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: map borders, every kind of access, the bank offset,
        // the wrap of the status sequence with all flag combinations, every
        // decoded port, the scroll registers from both sources and the
        // unused operation codes 5 and 7.
        issue_access(make_access(ambd_pkg::OP_MEM_READ,  16'h0000, 8'h00, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_MEM_READ,  16'h8000, 8'hff, 8'hff, 1'b1, 1'b1));
        issue_access(make_access(ambd_pkg::OP_MEM_READ,  16'hbfff, 8'h00, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_MEM_READ,  16'he7ff, 8'h00, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_MEM_READ,  16'he800, 8'h00, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_MEM_READ,  16'he803, 8'h00, 8'ha5, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_MEM_READ,  16'hefff, 8'h00, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_MEM_READ,  16'hffff, 8'h00, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_PORT_OUT,  16'h3409, 8'h5a, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_MEM_READ,  16'h8123, 8'h00, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_PORT_IN,   16'h0000, 8'h00, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_PORT_IN,   16'hff00, 8'h00, 8'h00, 1'b1, 1'b0));
        issue_access(make_access(ambd_pkg::OP_PORT_IN,   16'h0000, 8'h00, 8'h00, 1'b0, 1'b1));
        issue_access(make_access(ambd_pkg::OP_PORT_IN,   16'h0000, 8'h00, 8'h00, 1'b1, 1'b1));
        issue_access(make_access(ambd_pkg::OP_PORT_IN,   16'h0001, 8'h00, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_PORT_OUT,  16'h0001, 8'h00, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_PORT_OUT,  16'h0007, 8'h00, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_PORT_OUT,  16'h0006, 8'h00, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_PORT_OUT,  16'hff08, 8'h00, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_PORT_OUT,  16'h0000, 8'h00, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_MEM_WRITE, 16'he800, 8'hff, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_MEM_WRITE, 16'he801, 8'h80, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_MEM_WRITE, 16'he802, 8'h7e, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_MEM_WRITE, 16'he803, 8'h3c, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_MEM_WRITE, 16'hc000, 8'h11, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_MEM_WRITE, 16'hbfff, 8'h22, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_MEM_WRITE, 16'he804, 8'h33, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_MCU_SCROLL, 16'hfffe, 8'h12, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(ambd_pkg::OP_MCU_SCROLL, 16'h0001, 8'hfe, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(3'd5,                   16'he800, 8'h44, 8'h00, 1'b0, 1'b0));
        issue_access(make_access(3'd7,                   16'h0009, 8'h55, 8'h00, 1'b0, 1'b0));

        // Random part in three stretches: a slow receiver, then a slow
        // sender, then both at full rate.
        for (int stretch = 0; stretch < 3; stretch++)
        begin
            case (stretch)
                0:
                begin
                    tx_idle_pct = 6;
                    rx_idle_pct = 61;
                end
                1:
                begin
                    tx_idle_pct = 61;
                    rx_idle_pct = 6;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < 350; n++)
            begin
                // The receiver stops for a long stretch while accesses keep
                // coming, so both registers fill and tready drops.
                if (n == 120 && stretch != 1)
                    rx_hold_cycles = 60;
                // The sender stops until every decode has come back.
                if (n == 200)
                begin
                    s_tvalid <= 1'b0;
                    while (sb.outstanding() != 0)
                        @(posedge clk);
                end
                issue_access(random_access());
            end
        end

        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        // The idle wait catches any extra result from the input and output registers.
        repeat (8) @(posedge clk);

        $display("Sent %0d reads, %0d writes, %0d port ins, %0d port outs, %0d scroll bytes,",
                 sb.op_seen[ambd_pkg::OP_MEM_READ], sb.op_seen[ambd_pkg::OP_MEM_WRITE],
                 sb.op_seen[ambd_pkg::OP_PORT_IN], sb.op_seen[ambd_pkg::OP_PORT_OUT],
                 sb.op_seen[ambd_pkg::OP_MCU_SCROLL]);
        $display("%0d unused codes; checked %0d decodes, %0d field mismatches.",
                 sb.op_seen[5] + sb.op_seen[6] + sb.op_seen[7],
                 sb.decodes_checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### filelist.f
sv/ambd_pkg.sv
sv/arcade_main_bus_decoder.sv
tb/sv/arcade_main_bus_decoder_tb.sv
